// ===== rtl/mes_pkg.sv =====
// Shared types and constants for the margin edge scanner.
package mes_pkg;

  localparam int POSITION_BITS = 12;
  localparam int COUNT_BITS    = 13;
  localparam int SUM_BITS      = 17;
  localparam int AREA_BITS     = 16;
  localparam int GAP_BITS      = 12;
  localparam int EDGE_BITS     = 12;
  localparam int OUTCOME_BITS  = 2;
  localparam int PADDR_BITS    = 3;

  localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

  localparam logic [OUTCOME_BITS-1:0] OUTCOME_THRESHOLD = 2'd0;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_RUNS      = 2'd1;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_NO_INK    = 2'd2;
  localparam logic [OUTCOME_BITS-1:0] OUTCOME_UNUSED    = 2'd3;

  // Register select is the word address bit.
  localparam logic REG_DEFECT_AREA = 1'b0;
  localparam logic REG_GAP_LIMIT   = 1'b1;

  typedef struct packed {
    logic [POSITION_BITS-1:0] position;
    logic [COUNT_BITS-1:0]    dark_count;
    logic                     last;
  } sample_t;

  typedef struct packed {
    logic [EDGE_BITS-1:0]    edge_position;
    logic [OUTCOME_BITS-1:0] outcome;
  } result_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] defect_area;
    logic [GAP_BITS-1:0]  gap_limit;
  } cfg_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } result_push_t;

endpackage

// ===== rtl/mes_core.sv =====
// Scan state and per-sample update: run tracking, threshold check, edge pick.
module mes_core import mes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  sample_t      sample,
  input  cfg_t         cfg,
  output result_push_t push
);

  logic [SUM_BITS-1:0]      run_sum, run_sum_next;
  logic [POSITION_BITS-1:0] run_start, run_start_next;
  logic                     run_start_valid, run_start_valid_next;
  logic [POSITION_BITS-1:0] prior_start, prior_start_next;
  logic                     prior_start_valid, prior_start_valid_next;
  logic                     scan_done, scan_done_next;

  logic [SUM_BITS:0]        sum_wide;
  logic [SUM_BITS-1:0]      sum_sat;

  function automatic logic [POSITION_BITS-1:0] pick_edge(
    input logic [POSITION_BITS-1:0] cur,
    input logic [POSITION_BITS-1:0] prior,
    input logic                     prior_ok,
    input logic [GAP_BITS-1:0]      gap
  );
    logic [POSITION_BITS-1:0] span;
    span = (cur >= prior) ? (cur - prior) : (prior - cur);
    if (prior_ok && (span <= gap))
      return prior;
    return cur;
  endfunction

  assign sum_wide = {1'b0, run_sum} + (SUM_BITS+1)'(sample.dark_count);
  assign sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

  always_comb begin
    run_sum_next           = run_sum;
    run_start_next         = run_start;
    run_start_valid_next   = run_start_valid;
    prior_start_next       = prior_start;
    prior_start_valid_next = prior_start_valid;
    scan_done_next         = scan_done;
    push                   = '0;

    if (sample.last) begin
      if (!scan_done) begin
        push.valid = accept;
        if (!run_start_valid) begin
          push.data.edge_position = EDGE_BITS'(sample.position);
          push.data.outcome       = OUTCOME_NO_INK;
        end else begin
          push.data.edge_position = EDGE_BITS'(pick_edge(run_start, prior_start,
                                                         prior_start_valid, cfg.gap_limit));
          push.data.outcome       = OUTCOME_RUNS;
        end
      end
      run_sum_next           = '0;
      run_start_next         = '0;
      run_start_valid_next   = 1'b0;
      prior_start_next       = '0;
      prior_start_valid_next = 1'b0;
      scan_done_next         = 1'b0;
    end else if (!scan_done) begin
      if (sample.dark_count == '0) begin
        run_sum_next = '0;
      end else begin
        // first nonzero sample opens a new run
        if (run_sum == '0) begin
          if (run_start_valid) begin
            prior_start_next       = run_start;
            prior_start_valid_next = 1'b1;
          end
          run_start_next       = sample.position;
          run_start_valid_next = 1'b1;
        end
        run_sum_next = sum_sat;
        if (sum_sat >= SUM_BITS'(cfg.defect_area)) begin
          push.valid              = accept;
          push.data.edge_position = EDGE_BITS'(pick_edge(run_start_next, prior_start_next,
                                                         prior_start_valid_next,
                                                         cfg.gap_limit));
          push.data.outcome       = OUTCOME_THRESHOLD;
          scan_done_next          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_sum           <= '0;
      run_start         <= '0;
      run_start_valid   <= 1'b0;
      prior_start       <= '0;
      prior_start_valid <= 1'b0;
      scan_done         <= 1'b0;
    end else if (accept) begin
      run_sum           <= run_sum_next;
      run_start         <= run_start_next;
      run_start_valid   <= run_start_valid_next;
      prior_start       <= prior_start_next;
      prior_start_valid <= prior_start_valid_next;
      scan_done         <= scan_done_next;
    end
  end

endmodule

// ===== rtl/mes_out_buf.sv =====
// Result register with a skid entry so the input side keeps moving.
module mes_out_buf import mes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  result_push_t push,
  output logic         full,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result
);

  logic    skid_valid;
  result_t skid;
  logic    take;

  assign take = result_valid && !result_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      // input is stalled while the skid entry is occupied
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (!result_valid || take) begin
        result_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (push.valid) begin
      if (!result_valid || take) begin
        result <= push.data;
      end else begin
        skid <= push.data;
      end
    end
  end

endmodule

// ===== rtl/margin_edge_scan_top.sv =====
// Margin edge scanner top level: configuration registers, scan core, result buffer.
//
// Takes one profile sample per cycle unless sample_stall is high and returns
// at most one result per scan: outcome 0 when an ink run's summed dark count
// reaches defect_area (later samples are skipped until the last item), else
// outcome 1 or 2 on the last item. The state update is one 17-bit saturating
// add and compare between the scan state registers and the result register.
// A two-entry result buffer lets samples keep flowing while a result waits;
// sample_stall rises only when both entries are held. Registers: defect_area
// at 0x0, gap_limit at 0x4; write while idle.
module margin_edge_scan_top import mes_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t         cfg;
  result_push_t push;
  logic         buf_full;
  logic         accept;
  logic         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign accept  = sample_valid && !sample_stall;
  assign sample_stall = buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.defect_area <= AREA_BITS'(12);
      cfg.gap_limit   <= GAP_BITS'(4);
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_DEFECT_AREA: cfg.defect_area <= pwdata[AREA_BITS-1:0];
        REG_GAP_LIMIT:   cfg.gap_limit   <= pwdata[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEFECT_AREA: prdata = 32'(cfg.defect_area);
      REG_GAP_LIMIT:   prdata = 32'(cfg.gap_limit);
      default:         prdata = '0;
    endcase
  end

  mes_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (sample),
    .cfg    (cfg),
    .push   (push)
  );

  mes_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== rtl/mes_checker.sv =====
// Port-level checks for the margin edge scanner, bound to the top level.
module mes_checker import mes_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // a held result stays put until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !sample_stall)
    else $error("result buffer not empty after reset");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.outcome != OUTCOME_UNUSED)
    else $error("undefined outcome code");

  // input only backs up when a result is waiting at the output
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    sample_stall |-> result_valid)
    else $error("input stalled with no pending result");

endmodule

bind margin_edge_scan_top mes_checker u_mes_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ===== dv/tb_margin_edge_scan_top.sv =====
// Self-checking testbench for margin_edge_scan_top: random scans, edge prediction, register sweeps.
module tb_margin_edge_scan_top;
  import mes_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  margin_edge_scan_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scan state mirror and register copies
  logic [AREA_BITS-1:0]     cfg_area = 16'd12;
  logic [GAP_BITS-1:0]      cfg_gap  = 12'd4;
  logic [SUM_BITS-1:0]      ink_sum = '0;
  logic [POSITION_BITS-1:0] run_pos = '0;
  bit                       run_seen = 1'b0;
  logic [POSITION_BITS-1:0] prior_pos = '0;
  bit                       prior_seen = 1'b0;
  bit                       edge_found = 1'b0;

  sample_t pending_samples[$];
  result_t expected_edges[$];

  int  cycle_count = 0;
  int  fail_count = 0;
  int  samples_sent = 0;
  int  scans_closed = 0;
  int  edges_checked = 0;
  int  settings_used = 1;
  int  queued_count = 0;
  int  send_idle_pct = 15;
  int  stall_pct = 15;
  bit  sample_fire = 1'b0;

  function automatic logic [EDGE_BITS-1:0] gap_pick();
    logic [POSITION_BITS-1:0] span;
    if (!prior_seen)
      return run_pos;
    span = (run_pos >= prior_pos) ? run_pos - prior_pos : prior_pos - run_pos;
    return (span <= cfg_gap) ? prior_pos : run_pos;
  endfunction

  // Advances the mirror by one sample; returns 1 when an edge result is due.
  function automatic bit edge_predict(input sample_t s, output result_t r);
    logic [SUM_BITS:0] sum_next;
    bit                hit;
    hit = 1'b0;
    r = '0;
    if (s.last) begin
      if (!edge_found) begin
        hit = 1'b1;
        if (!run_seen) begin
          r.edge_position = s.position;
          r.outcome = OUTCOME_NO_INK;
        end else begin
          r.edge_position = gap_pick();
          r.outcome = OUTCOME_RUNS;
        end
      end
      ink_sum = '0;
      run_pos = '0;
      run_seen = 1'b0;
      prior_pos = '0;
      prior_seen = 1'b0;
      edge_found = 1'b0;
    end else if (!edge_found) begin
      if (s.dark_count == '0) begin
        ink_sum = '0;
      end else begin
        if (ink_sum == '0) begin
          if (run_seen) begin
            prior_pos = run_pos;
            prior_seen = 1'b1;
          end
          run_pos = s.position;
          run_seen = 1'b1;
        end
        sum_next = ink_sum + s.dark_count;
        ink_sum = (sum_next > SUM_MAX) ? SUM_MAX : sum_next[SUM_BITS-1:0];
        if (ink_sum >= cfg_area) begin
          hit = 1'b1;
          r.edge_position = gap_pick();
          r.outcome = OUTCOME_THRESHOLD;
          edge_found = 1'b1;
        end
      end
    end
    return hit;
  endfunction

  function automatic void add_sample(input int unsigned pos, input int unsigned cnt, input bit lst);
    sample_t s;
    s.position = POSITION_BITS'(pos);
    s.dark_count = COUNT_BITS'(cnt);
    s.last = lst;
    pending_samples.push_back(s);
    queued_count++;
  endfunction

  // One scan: blank rows, ink runs of random length and weight, then the stop item.
  function automatic void add_scan();
    int unsigned row;
    int unsigned runs;
    int unsigned len;
    int unsigned top;
    int unsigned lo;
    bit          heavy;
    row = $urandom_range(0, 4095);
    runs = $urandom_range(0, 4);
    for (int r = 0; r < runs; r++) begin
      if ($urandom_range(0, 5) == 0)
        row += $urandom_range(0, 4095);
      repeat ($urandom_range((r == 0) ? 0 : 1, 4)) begin
        add_sample(row, 0, 1'b0);
        row++;
      end
      heavy = ($urandom_range(0, 3) == 0);
      top = ($urandom_range(0, 4) == 0) ? 4096 : cfg_area / 4 + 1;
      if (top > 4096)
        top = 4096;
      lo = heavy ? top / 2 + 1 : 1;
      len = $urandom_range(1, (cfg_area > 8000) ? 24 : 6);
      repeat (len) begin
        add_sample(row, $urandom_range(lo, top), 1'b0);
        row++;
      end
    end
    add_sample(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : row,
               $urandom_range(0, 4096), 1'b1);
  endfunction

  function automatic void add_noise();
    int unsigned cnt;
    case ($urandom_range(0, 3))
      0: cnt = 0;
      1: cnt = 4096;
      default: cnt = $urandom_range(0, 4096);
    endcase
    add_sample($urandom_range(0, 4095), cnt, $urandom_range(0, 9) == 0);
  endfunction

  task automatic reg_write(input logic sel, input logic [31:0] value);
    logic [31:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_DEFECT_AREA)
      cfg_area = value[AREA_BITS-1:0];
    else
      cfg_gap = value[GAP_BITS-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((sel == REG_DEFECT_AREA && got[AREA_BITS-1:0] !== cfg_area) ||
        (sel == REG_GAP_LIMIT && got[GAP_BITS-1:0] !== cfg_gap)) begin
      fail_count++;
      if (fail_count <= 10)
        $display("register readback at %0d: wrote 0x%0h, read 0x%0h", sel, value, got);
    end
  endtask

  task automatic set_scan_config(input int unsigned area, input int unsigned gap);
    reg_write(REG_DEFECT_AREA, area);
    reg_write(REG_GAP_LIMIT, gap);
    settings_used++;
  endtask

  // Sender holds off until every queued transaction is out and every edge is back.
  task automatic wait_drained();
    while (pending_samples.size() != 0 || sample_valid || expected_edges.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_random(input int count, input int noise_pct);
    int target;
    target = queued_count + count;
    while (queued_count < target) begin
      if ($urandom_range(0, 99) < noise_pct)
        add_noise();
      else
        add_scan();
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_fire) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        sample <= pending_samples.pop_front();
        sample_valid <= 1'b1;
      end else begin
        sample_valid <= 1'b0;
      end
    end
    result_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // monitor, predictor and scoreboard
  always @(posedge clk) begin
    result_t want;
    result_t got;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end else begin
      sample_fire = !rst && sample_valid && !sample_stall;
      if (sample_fire) begin
        samples_sent++;
        if (sample.last)
          scans_closed++;
        if (edge_predict(sample, want))
          expected_edges.push_back(want);
      end
      if (!rst && result_valid && !result_stall) begin
        got = result;
        if (expected_edges.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: edge %0d outcome %0d", got.edge_position, got.outcome);
        end else begin
          want = expected_edges.pop_front();
          edges_checked++;
          if (got.edge_position !== want.edge_position || got.outcome !== want.outcome) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result mismatch: expected edge %0d outcome %0d, got edge %0d outcome %0d",
                       want.edge_position, want.outcome, got.edge_position, got.outcome);
          end
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values: no ink, early threshold with ignored tail, close and far runs
    add_sample(4095, 0, 1'b1);
    add_sample(0, 4096, 1'b0);
    add_sample(1, 5, 1'b0);
    add_sample(0, 0, 1'b1);
    add_sample(10, 3, 1'b0);
    add_sample(11, 0, 1'b0);
    add_sample(13, 2, 1'b0);
    add_sample(20, 0, 1'b1);
    add_sample(100, 1, 1'b0);
    add_sample(101, 0, 1'b0);
    add_sample(200, 1, 1'b0);
    add_sample(300, 0, 1'b1);
    add_sample(8, 1, 1'b0);
    add_sample(9, 0, 1'b0);
    add_sample(10, 11, 1'b0);
    add_sample(11, 1, 1'b0);
    add_sample(12, 9, 1'b1);
    wait_drained();

    // zero gap: prior start only taken when equal
    set_scan_config(65535, 0);
    add_sample(7, 1, 1'b0);
    add_sample(8, 0, 1'b0);
    add_sample(7, 1, 1'b0);
    add_sample(0, 0, 1'b1);
    add_sample(20, 1, 1'b0);
    add_sample(21, 0, 1'b0);
    add_sample(21, 1, 1'b0);
    add_sample(0, 0, 1'b1);
    add_random(100, 10);
    wait_drained();

    // zero area: first ink sample is the edge
    set_scan_config(0, 4095);
    add_sample(5, 1, 1'b0);
    add_sample(6, 7, 1'b0);
    add_sample(9, 0, 1'b1);
    add_random(100, 10);
    wait_drained();

    set_scan_config(65535, 4095);
    add_random(150, 5);
    wait_drained();

    // long stretch with neither side idling
    send_idle_pct = 0;
    stall_pct = 0;
    set_scan_config(1, 1);
    add_random(120, 15);
    wait_drained();
    send_idle_pct = 15;
    stall_pct = 15;

    repeat (3) begin
      set_scan_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 1500),
                      $urandom_range(1, 64));
      add_random(100, 15);
      wait_drained();
    end

    if (expected_edges.size() != 0) begin
      fail_count++;
      $display("%0d expected results never arrived", expected_edges.size());
    end
    $display("%0d samples over %0d closed scans, %0d edge results checked",
             samples_sent, scans_closed, edges_checked);
    $display("%0d register settings, including zero and full-scale area and gap",
             settings_used);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
